/* src/wsd_pkg.sv */
package wsd_pkg;

    localparam int DEF_CAPACITY    = 256;
    localparam int DEF_HANDLE_BITS = 32;

    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int JOB_W    = 32;
    localparam int COUNT_W  = 9;

    localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STEAL = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic exec;     // carry out the operation of the accepted word
        logic capture;  // load the read data into the result
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic rd_go;    // the pending word takes a handle out of the store
    } dp_stat_t;

endpackage

/* src/wsd_ctrl.sv */
module wsd_ctrl
    import wsd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t dp_stat,
    output ctl_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd.exec    = 1'b0;
        cmd.capture = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.exec   = 1'b1;
                    state_next = dp_stat.rd_go ? ST_READ : ST_DONE;
                end
            end
            ST_READ:
            begin
                cmd.capture = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_DONE);

    a_read_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |=> state_reg == ST_DONE)
        else $error("read cycle not followed by result");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && !in_ready)
        else $error("stalled result dropped");

    a_exec_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> in_ready && !out_valid)
        else $error("operation started while busy");

endmodule

/* src/wsd_datapath.sv */
module wsd_datapath
    import wsd_pkg::*;
#(
    parameter int CAPACITY    = DEF_CAPACITY,
    parameter int HANDLE_BITS = DEF_HANDLE_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctl_cmd_t            cmd,
    output dp_stat_t            dp_stat,
    input  logic [MODE_W-1:0]   mode,
    input  logic [JOB_W-1:0]    job_handle,
    output logic [STATUS_W-1:0] status,
    output logic [JOB_W-1:0]    job_out,
    output logic [COUNT_W-1:0]  count,
    output logic                is_empty
);

    localparam int PTR_W  = $clog2(2 * CAPACITY);
    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(2 * CAPACITY - 1);
    localparam logic [PTR_W-1:0] CAP_PTR  = PTR_W'(CAPACITY);
    localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);

    logic [HANDLE_BITS-1:0] mem [CAPACITY];
    logic [HANDLE_BITS-1:0] rdata_reg;

    logic [PTR_W-1:0]       top_reg, top_next;
    logic [PTR_W-1:0]       bot_reg, bot_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [HANDLE_BITS-1:0] job_reg;

    logic                   wr_en;
    logic [PTR_W-1:0]       wr_ptr, rd_ptr, bot_dec, bot_inc, top_inc;
    logic [ADDR_W-1:0]      wr_addr, rd_addr;
    logic                   is_full, is_void;

    function automatic logic [ADDR_W-1:0] slot_of(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] s;
        s = (p >= CAP_PTR) ? (p - CAP_PTR) : p;
        return s[ADDR_W-1:0];
    endfunction

    assign is_full = (count_reg == CAP_CNT);
    assign is_void = (count_reg == '0);

    assign bot_inc = (bot_reg == PTR_LAST) ? '0 : bot_reg + 1'b1;
    assign bot_dec = (bot_reg == '0) ? PTR_LAST : bot_reg - 1'b1;
    assign top_inc = (top_reg == PTR_LAST) ? '0 : top_reg + 1'b1;

    assign dp_stat.rd_go = !is_void && (mode == MODE_POP || mode == MODE_STEAL);

    always_comb
    begin
        top_next    = top_reg;
        bot_next    = bot_reg;
        count_next  = count_reg;
        status_next = STAT_OK;
        wr_en       = 1'b0;
        wr_ptr      = bot_reg;
        rd_ptr      = top_reg;
        case (mode)
            MODE_PUSH:
            begin
                if (is_full)
                begin
                    status_next = STAT_FULL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    bot_next   = bot_inc;
                    count_next = count_reg + 1'b1;
                end
            end
            MODE_POP:
            begin
                rd_ptr = bot_dec;
                if (is_void)
                begin
                    status_next = STAT_EMPTY;
                end
                else
                begin
                    bot_next   = bot_dec;
                    count_next = count_reg - 1'b1;
                end
            end
            MODE_STEAL:
            begin
                if (is_void)
                begin
                    status_next = STAT_EMPTY;
                end
                else
                begin
                    top_next   = top_inc;
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                status_next = STAT_OK;
            end
        endcase
    end

    assign wr_addr = slot_of(wr_ptr);
    assign rd_addr = slot_of(rd_ptr);

    // slot store, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_en)
        begin
            mem[wr_addr] <= HANDLE_BITS'(job_handle);
        end
        if (cmd.exec)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg   <= '0;
            bot_reg   <= '0;
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            top_reg   <= top_next;
            bot_reg   <= bot_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            status_reg <= status_next;
            job_reg    <= '0;
        end
        else if (cmd.capture)
        begin
            job_reg <= rdata_reg;
        end
    end

    assign status   = status_reg;
    assign job_out  = JOB_W'(job_reg);
    assign count    = COUNT_W'(count_reg);
    assign is_empty = (count_reg == '0);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("count beyond capacity");

    a_take_dec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && dp_stat.rd_go |=> count_reg == $past(count_reg) - 1'b1)
        else $error("take did not lower count");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && mode == MODE_PUSH && is_full |=> status_reg == STAT_FULL && is_full)
        else $error("push at capacity not reported full");

endmodule

/* src/work_stealing_deque.sv */
// bounded work-stealing deque of job handles
// input channel: in_valid/in_ready with mode (0 push, 1 pop, 2 steal) and job_handle
// output channel: out_valid/out_ready with status, job_out, count and is_empty;
// exactly one result word for every accepted input word, in order
// push stores at the bottom, pop takes the newest from the bottom, steal the oldest
// from the top; status 1 means nothing to take, status 2 means no room
// one word is worked at a time: push, a failed take or mode 3 gives its result
// in the cycle after acceptance, while a pop or steal first passes through a read
// state for the registered read of the slot memory; the next word is taken in the
// cycle after the result is taken
// a stalled receiver holds the result and keeps in_ready low until it is taken
// reset clears the pointers and the count; the slot memory is not cleared, a slot
// is only read after it has been written, so the deque is usable right away
module work_stealing_deque
    import wsd_pkg::*;
#(
    parameter int CAPACITY    = DEF_CAPACITY,
    parameter int HANDLE_BITS = DEF_HANDLE_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [MODE_W-1:0]   mode,
    input  logic [JOB_W-1:0]    job_handle,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] status,
    output logic [JOB_W-1:0]    job_out,
    output logic [COUNT_W-1:0]  count,
    output logic                is_empty
);

    ctl_cmd_t cmd;
    dp_stat_t dp_stat;

    wsd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dp_stat   (dp_stat),
        .cmd       (cmd)
    );

    wsd_datapath #(
        .CAPACITY    (CAPACITY),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .dp_stat    (dp_stat),
        .mode       (mode),
        .job_handle (job_handle),
        .status     (status),
        .job_out    (job_out),
        .count      (count),
        .is_empty   (is_empty)
    );

endmodule
